>>> hw/rtl/timer_request_table_macros.svh
// ----------------------------------------------------------------------------
// timer request table assertion macros
// concurrent assertion wrappers clocked on aclk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef TIMER_REQUEST_TABLE_MACROS_SVH
`define TIMER_REQUEST_TABLE_MACROS_SVH

// same-cycle implication
`define TRQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/trq_pkg.sv
// ----------------------------------------------------------------------------
// trq_pkg
// shared types, codes and constants of the timer request table
// ----------------------------------------------------------------------------
`default_nettype none

package trq_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int RESULT_LIMIT    = 16;
    localparam int FIRE_W          = $clog2(RESULT_LIMIT + 1);
    localparam int FW              = 32;
    localparam int KIND_W          = 3;
    localparam int OP_W            = 1;
    localparam int TDATA_W         = 3 * FW;

    typedef enum logic [KIND_W-1:0] {
        KIND_STORED  = 3'd0,
        KIND_RESCHED = 3'd1,
        KIND_DROPPED = 3'd2,
        KIND_FIRED   = 3'd3,
        KIND_NONE    = 3'd4
    } kind_t;

    typedef struct packed {
        logic load_in;
        logic scan_clear;
        logic tick_start;
        logic req_step;
        logic req_commit;
        logic tick_step;
        logic tick_fire;
        logic tick_last;
    } cmd_t;

    typedef struct packed {
        logic in_tick;
        logic scan_end;
        logic hit;
        logic pend_valid;
        logic limit_hit;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/trq_ctrl.sv
// ----------------------------------------------------------------------------
// trq_ctrl
// sequencer for request lookup, tick scans, entry removal and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module trq_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid_i,
    output logic                  s_tready_o,
    input  trq_pkg::status_t      status_i,
    output trq_pkg::cmd_t         cmd_o
);
    import trq_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_REQ_SCAN  = 6'b000010,
        ST_REQ_OUT   = 6'b000100,
        ST_TICK_SCAN = 6'b001000,
        ST_TICK_STEP = 6'b010000,
        ST_TICK_LAST = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd_o      = '0;
        state_next = state_reg;
        s_tready_o = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid_i) begin
                    cmd_o.load_in    = 1'b1;
                    cmd_o.scan_clear = 1'b1;
                    if (status_i.in_tick) begin
                        cmd_o.tick_start = 1'b1;
                        state_next       = ST_TICK_SCAN;
                    end else begin
                        state_next = ST_REQ_SCAN;
                    end
                end
            end
            ST_REQ_SCAN: begin
                if (status_i.hit || status_i.scan_end) begin
                    state_next = ST_REQ_OUT;
                end else begin
                    cmd_o.req_step = 1'b1;
                end
            end
            ST_REQ_OUT: begin
                if (status_i.out_free) begin
                    cmd_o.req_commit = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_TICK_SCAN: begin
                if (status_i.scan_end) begin
                    state_next = ST_TICK_STEP;
                end else begin
                    cmd_o.tick_step = 1'b1;
                end
            end
            ST_TICK_STEP: begin
                if (!status_i.hit) begin
                    state_next = ST_TICK_LAST;
                end else if (!status_i.pend_valid || status_i.out_free) begin
                    cmd_o.tick_fire  = 1'b1;
                    cmd_o.scan_clear = 1'b1;
                    state_next       = status_i.limit_hit ? ST_TICK_LAST : ST_TICK_SCAN;
                end
            end
            ST_TICK_LAST: begin
                if (status_i.out_free) begin
                    cmd_o.tick_last = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/trq_datapath.sv
// ----------------------------------------------------------------------------
// trq_datapath
// compacted request table, one-entry-a-cycle scan unit and output register
// ----------------------------------------------------------------------------
`default_nettype none

module trq_datapath #(
    parameter int TABLE_DEPTH = trq_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  trq_pkg::cmd_t                     cmd_i,
    output trq_pkg::status_t                  status_o,
    input  wire logic [trq_pkg::TDATA_W-1:0]  s_tdata_i,
    input  wire logic [trq_pkg::OP_W-1:0]     s_tuser_i,
    input  wire logic                         m_tready_i,
    output logic                              m_tvalid_o,
    output logic [trq_pkg::TDATA_W-1:0]       m_tdata_o,
    output logic [trq_pkg::KIND_W-1:0]        m_tuser_o,
    output logic                              m_tlast_o
);
    import trq_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [FW-1:0]     slot_id_reg   [TABLE_DEPTH];
    logic [FW-1:0]     slot_time_reg [TABLE_DEPTH];
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     idx_reg;
    logic              hit_reg;
    logic [IW-1:0]     best_reg;
    logic [FW-1:0]     best_id_reg;
    logic [FW-1:0]     best_time_reg;
    logic [FW-1:0]     in_id_reg;
    logic [FW-1:0]     in_trig_reg;
    logic [FW-1:0]     in_now_reg;
    logic              pend_valid_reg;
    logic [FW-1:0]     pend_id_reg;
    logic [FW-1:0]     pend_trig_reg;
    logic [FIRE_W-1:0] fired_reg;

    logic              out_valid_reg;
    kind_t             out_kind_reg;
    logic [FW-1:0]     out_id_reg;
    logic [FW-1:0]     out_trig_reg;
    logic [FW-1:0]     out_when_reg;
    logic              out_last_reg;

    logic              out_load;
    kind_t             out_kind_next;
    logic [FW-1:0]     out_id_next;
    logic [FW-1:0]     out_trig_next;
    logic [FW-1:0]     out_when_next;
    logic              out_last_next;

    logic [FW-1:0]     scan_id;
    logic [FW-1:0]     scan_time;
    logic [FW-1:0]     due_diff;
    logic [FW-1:0]     ord_diff;
    logic              scan_take;
    logic              full;

    assign scan_id   = slot_id_reg[idx_reg[IW-1:0]];
    assign scan_time = slot_time_reg[idx_reg[IW-1:0]];
    assign due_diff  = in_now_reg - scan_time;
    assign ord_diff  = best_time_reg - scan_time;
    // due, and no later than the current best (ties go to the later entry)
    assign scan_take = !due_diff[FW-1] && (!hit_reg || !ord_diff[FW-1]);
    assign full      = (cnt_reg == CW'(TABLE_DEPTH));

    assign status_o.in_tick    = s_tuser_i[0];
    assign status_o.scan_end   = (idx_reg == cnt_reg);
    assign status_o.hit        = hit_reg;
    assign status_o.pend_valid = pend_valid_reg;
    assign status_o.limit_hit  = (fired_reg == FIRE_W'(RESULT_LIMIT - 1));
    assign status_o.out_free   = !out_valid_reg || m_tready_i;

    always_comb begin
        out_load      = 1'b0;
        out_kind_next = KIND_FIRED;
        out_id_next   = pend_id_reg;
        out_trig_next = pend_trig_reg;
        out_when_next = in_now_reg;
        out_last_next = 1'b0;
        if (cmd_i.req_commit) begin
            out_load      = 1'b1;
            out_kind_next = hit_reg ? KIND_RESCHED : (full ? KIND_DROPPED : KIND_STORED);
            out_id_next   = in_id_reg;
            out_trig_next = in_trig_reg;
            out_when_next = '0;
            out_last_next = 1'b1;
        end else if (cmd_i.tick_fire) begin
            out_load = pend_valid_reg;
        end else if (cmd_i.tick_last) begin
            out_load      = 1'b1;
            out_last_next = 1'b1;
            if (!pend_valid_reg) begin
                out_kind_next = KIND_NONE;
                out_id_next   = '0;
                out_trig_next = '0;
            end
        end
    end

    // table contents
    always_ff @(posedge aclk) begin
        if (cmd_i.req_commit) begin
            if (hit_reg) begin
                slot_time_reg[best_reg] <= in_trig_reg;
            end else if (!full) begin
                slot_id_reg[cnt_reg[IW-1:0]]   <= in_id_reg;
                slot_time_reg[cnt_reg[IW-1:0]] <= in_trig_reg;
            end
        end else if (cmd_i.tick_fire) begin
            // close the gap left by the removed entry
            for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
                if (IW'(i) >= best_reg) begin
                    slot_id_reg[i]   <= slot_id_reg[i + 1];
                    slot_time_reg[i] <= slot_time_reg[i + 1];
                end
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            idx_reg        <= '0;
            hit_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            fired_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd_i.scan_clear) begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end else if (cmd_i.req_step) begin
                idx_reg <= idx_reg + CW'(1);
                if (scan_id == in_id_reg) begin
                    hit_reg <= 1'b1;
                end
            end else if (cmd_i.tick_step) begin
                idx_reg <= idx_reg + CW'(1);
                if (scan_take) begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd_i.tick_start) begin
                pend_valid_reg <= 1'b0;
                fired_reg      <= '0;
            end else if (cmd_i.tick_fire) begin
                pend_valid_reg <= 1'b1;
                fired_reg      <= fired_reg + FIRE_W'(1);
            end
            if (cmd_i.req_commit && !hit_reg && !full) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (cmd_i.tick_fire) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready_i) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd_i.load_in) begin
            in_id_reg   <= s_tdata_i[FW-1:0];
            in_trig_reg <= s_tdata_i[2*FW-1:FW];
            in_now_reg  <= s_tdata_i[3*FW-1:2*FW];
        end
        if ((cmd_i.req_step && scan_id == in_id_reg) || (cmd_i.tick_step && scan_take)) begin
            best_reg      <= idx_reg[IW-1:0];
            best_id_reg   <= scan_id;
            best_time_reg <= scan_time;
        end
        if (cmd_i.tick_fire) begin
            pend_id_reg   <= best_id_reg;
            pend_trig_reg <= best_time_reg;
        end
        if (out_load) begin
            out_kind_reg <= out_kind_next;
            out_id_reg   <= out_id_next;
            out_trig_reg <= out_trig_next;
            out_when_reg <= out_when_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid_o = out_valid_reg;
    assign m_tdata_o  = {out_when_reg, out_trig_reg, out_id_reg};
    assign m_tuser_o  = out_kind_reg;
    assign m_tlast_o  = out_last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/timer_request_table.sv
// a request scans the filled entries until its id matches or the scan ends, then
// gives its result once the output register is free; a tick scans the table once per
// fired entry and once more when fewer than 16 fire, then gives the final result
// every scan runs one entry a cycle over the filled part of the table
// one item is worked at a time; the next is taken while a result waits in the output register
// reset: synchronous, active low; table emptied by clearing the fill count
// ----------------------------------------------------------------------------
// timer_request_table
// pending timer request table with reschedule, append and earliest-first firing
// ----------------------------------------------------------------------------
`default_nettype none

module timer_request_table #(
    parameter int TABLE_DEPTH = trq_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // timer_id, trig, now
    input  wire logic [trq_pkg::TDATA_W-1:0]  s_tdata,
    // op
    input  wire logic [trq_pkg::OP_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // fired_id, fired_trigger, fire_time
    output logic [trq_pkg::TDATA_W-1:0]       m_tdata,
    // kind
    output logic [trq_pkg::KIND_W-1:0]        m_tuser,
    output logic                              m_tlast
);
    import trq_pkg::*;

    cmd_t    cmd;
    status_t status;

    trq_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid_i (s_tvalid),
        .s_tready_o (s_tready),
        .status_i   (status),
        .cmd_o      (cmd)
    );

    trq_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_i      (cmd),
        .status_o   (status),
        .s_tdata_i  (s_tdata),
        .s_tuser_i  (s_tuser),
        .m_tready_i (m_tready),
        .m_tvalid_o (m_tvalid),
        .m_tdata_o  (m_tdata),
        .m_tuser_o  (m_tuser),
        .m_tlast_o  (m_tlast)
    );

endmodule

`default_nettype wire

>>> hw/rtl/trq_checker.sv
// ----------------------------------------------------------------------------
// trq_checker
// port-level checks of the timer request table, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "timer_request_table_macros.svh"

module trq_checker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [trq_pkg::TDATA_W-1:0]  m_tdata,
    input  wire logic [trq_pkg::KIND_W-1:0]   m_tuser,
    input  wire logic                         m_tlast
);
    import trq_pkg::*;

    logic [1:0] open_reg;
    logic       in_acc;
    logic       out_end;

    assign in_acc  = s_tvalid && s_tready;
    assign out_end = m_tvalid && m_tready && m_tlast;

    // items accepted whose final result has not yet been taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else if (in_acc && !out_end) begin
            open_reg <= open_reg + 2'd1;
        end else if (!in_acc && out_end) begin
            open_reg <= open_reg - 2'd1;
        end
    end

    `TRQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
    `TRQ_ASSERT_SAME(a_no_orphan, m_tvalid, open_reg != 2'd0, "result without an open item")
    `TRQ_ASSERT_SAME(a_one_ahead, in_acc, open_reg == 2'd0 || open_reg == 2'd1, "item taken too far ahead")
    `TRQ_ASSERT_SAME(a_single_last, m_tvalid && (m_tuser == KIND_STORED || m_tuser == KIND_RESCHED || m_tuser == KIND_DROPPED || m_tuser == KIND_NONE), m_tlast, "single result without tlast")

endmodule

bind timer_request_table trq_checker u_trq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
